// ----- rtl/lprd_pkg.sv -----
// Package for the length-prefixed record deframer.
// Holds the item structs, header constants and error codes.
// No dependencies; the deframer top and the parser import it.
package lprd_pkg;

  // Header byte: the high nibble must carry this pattern.
  localparam logic [3:0] HDR_MAGIC = 4'hF;

  // Varint length bytes: value bits per byte and continuation bit.
  localparam int unsigned VARINT_BITS = 7;
  localparam int unsigned VARINT_CONT = 7;

  // Error codes carried on the result channel.
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MAGIC  = 2'd1,
    ERR_LENGTH = 2'd2
  } err_e;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_stream;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] record_length;
    logic        first_of_record;
    logic        last_of_record;
    logic        empty_record;
    err_e        error_code;
  } out_item_t;

endpackage

// ----- rtl/lprd_in_if.sv -----
// Input channel of the deframer: valid/ready handshake with one stream byte.
// Standalone; no package needed.
interface lprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_stream;

  modport source (output valid, output data_byte, output start_of_stream, input ready);
  modport sink   (input valid, input data_byte, input start_of_stream, output ready);
endinterface

// ----- rtl/lprd_out_if.sv -----
// Result channel of the deframer: valid/ready handshake with one payload item.
// Standalone; no package needed.
interface lprd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [31:0] record_length;
  logic        first_of_record;
  logic        last_of_record;
  logic        empty_record;
  logic [1:0]  error_code;

  modport source (output valid, output payload_byte, output record_length,
                  output first_of_record, output last_of_record,
                  output empty_record, output error_code, input ready);
  modport sink   (input valid, input payload_byte, input record_length,
                  input first_of_record, input last_of_record,
                  input empty_record, input error_code, output ready);
endinterface

// ----- rtl/length_prefixed_record_deframer.sv -----
// Length-prefixed record deframer: takes one stream byte per cycle while the
// result side is ready and gives one result item per payload byte, per empty
// record and per error. Each byte passes in order through the input slot, the
// combinational parser and the result slot. Input ready follows the
// result slot, so a stall on the result side holds the input after one buffered
// byte. LEN_BITS (8 to 64) sets the width of the decoded length; record_length
// carries its low 32 bits. Depends on lprd_pkg, lprd_in_if, lprd_out_if,
// lprd_pipe_reg and lprd_parser.
module length_prefixed_record_deframer #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lprd_in_if.sink    in_i,
  lprd_out_if.source out_o
);
  import lprd_pkg::*;

  localparam int unsigned IN_W  = $bits(in_item_t);
  localparam int unsigned OUT_W = $bits(out_item_t);

  in_item_t  in_item;
  in_item_t  slot_item;
  out_item_t res_item;
  out_item_t out_item;
  logic      slot_valid;
  logic      slot_ready;
  logic      res_valid;
  logic      res_ready;
  logic      out_valid;

  assign in_item.data_byte       = in_i.data_byte;
  assign in_item.start_of_stream = in_i.start_of_stream;

  // Input slot.
  lprd_pipe_reg #(
    .WIDTH (IN_W)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .data_i  (in_item),
    .ready_o (in_i.ready),
    .valid_o (slot_valid),
    .data_o  (slot_item),
    .ready_i (slot_ready)
  );

  // Parser.
  lprd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (slot_valid),
    .in_item_i   (slot_item),
    .in_ready_o  (slot_ready),
    .res_valid_o (res_valid),
    .res_o       (res_item),
    .res_ready_i (res_ready)
  );

  // Result slot.
  lprd_pipe_reg #(
    .WIDTH (OUT_W)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .data_i  (res_item),
    .ready_o (res_ready),
    .valid_o (out_valid),
    .data_o  (out_item),
    .ready_i (out_o.ready)
  );

  assign out_o.valid           = out_valid;
  assign out_o.payload_byte    = out_item.payload_byte;
  assign out_o.record_length   = out_item.record_length;
  assign out_o.first_of_record = out_item.first_of_record;
  assign out_o.last_of_record  = out_item.last_of_record;
  assign out_o.empty_record    = out_item.empty_record;
  assign out_o.error_code      = out_item.error_code;

endmodule

// ----- rtl/lprd_pipe_reg.sv -----
// One-entry pipeline register with valid/ready flow control.
// Used for the input slot and the result slot of the deframer; no dependencies.
module lprd_pipe_reg #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             ready_i
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  // The slot takes a new item when empty or when its item leaves this cycle.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

// ----- rtl/lprd_parser.sv -----
// Record parser of the deframer: header check, varint length decode and
// payload marking, one byte per cycle while the result side is ready. Depends on lprd_pkg.
module lprd_parser #(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  lprd_pkg::in_item_t in_item_i,
  output logic               in_ready_o,
  output logic               res_valid_o,
  output lprd_pkg::out_item_t res_o,
  input  logic               res_ready_i
);
  import lprd_pkg::*;

  // Shift is held at its first value at or above LEN_BITS, so it never exceeds LEN_BITS+6.
  localparam int unsigned SHW = $clog2(LEN_BITS + VARINT_BITS);
  localparam int unsigned WW  = LEN_BITS + VARINT_BITS;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_HALTED
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [3:0]          bytes_left_q, bytes_left_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic [SHW-1:0]      shift_q, shift_d;
  logic                open_q, open_d;
  logic [LEN_BITS-1:0] pay_left_q, pay_left_d;
  logic                first_q, first_d;

  logic                fire;
  logic [7:0]          b;
  logic [6:0]          v;
  phase_e              phase_cur;
  logic [WW-1:0]       v_wide;
  logic [LEN_BITS+31:0] acc_ext;
  logic                len_err;
  logic                res_valid;
  out_item_t           res;

  assign fire       = in_valid_i && res_ready_i;
  assign in_ready_o = res_ready_i;
  assign b          = in_item_i.data_byte;
  assign v          = b[VARINT_BITS-1:0];
  assign phase_cur  = in_item_i.start_of_stream ? PH_HEADER : phase_q;
  assign v_wide     = WW'(v) << shift_q;
  assign acc_ext    = {32'b0, acc_q};

  // Length group check: a set bit landing at or beyond LEN_BITS is an error.
  always_comb begin
    if (shift_q >= SHW'(LEN_BITS)) begin
      len_err = (v != 7'd0);
    end else begin
      len_err = |v_wide[WW-1:LEN_BITS];
    end
  end

  // Next state and result for the byte at the head of the input slot.
  always_comb begin
    phase_d      = phase_cur;
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    shift_d      = shift_q;
    open_d       = open_q;
    pay_left_d   = pay_left_q;
    first_d      = first_q;
    res_valid    = 1'b0;
    res          = '0;
    res.error_code = ERR_NONE;

    unique case (phase_cur)
      PH_HEADER: begin
        if (b[7:4] != HDR_MAGIC) begin
          phase_d        = PH_HALTED;
          res_valid      = 1'b1;
          res.error_code = ERR_MAGIC;
        end else begin
          bytes_left_d = b[3:0];
          acc_d        = '0;
          shift_d      = '0;
          open_d       = 1'b1;
          pay_left_d   = '0;
          first_d      = 1'b0;
          if (b[3:0] == 4'd0) begin
            // No length bytes: the record is empty.
            phase_d            = PH_HEADER;
            res_valid          = 1'b1;
            res.last_of_record = 1'b1;
            res.empty_record   = 1'b1;
          end else begin
            phase_d = PH_LENGTH;
          end
        end
      end

      PH_LENGTH: begin
        if (open_q && len_err) begin
          phase_d        = PH_HALTED;
          res_valid      = 1'b1;
          res.error_code = ERR_LENGTH;
        end else begin
          if (open_q) begin
            if (shift_q < SHW'(LEN_BITS)) begin
              acc_d = acc_q | v_wide[LEN_BITS-1:0];
            end
            if (!b[VARINT_CONT]) begin
              open_d = 1'b0;
            end else if (shift_q < SHW'(LEN_BITS)) begin
              shift_d = shift_q + SHW'(VARINT_BITS);
            end
          end
          bytes_left_d = bytes_left_q - 4'd1;
          // Last counted length byte: the length is final.
          if (bytes_left_q == 4'd1) begin
            if (acc_d == '0) begin
              phase_d            = PH_HEADER;
              res_valid          = 1'b1;
              res.last_of_record = 1'b1;
              res.empty_record   = 1'b1;
            end else begin
              phase_d    = PH_PAYLOAD;
              pay_left_d = acc_d;
              first_d    = 1'b1;
            end
          end
        end
      end

      PH_PAYLOAD: begin
        res_valid           = 1'b1;
        res.payload_byte    = b;
        res.record_length   = acc_ext[31:0];
        res.first_of_record = first_q;
        res.last_of_record  = (pay_left_q == LEN_BITS'(1));
        first_d             = 1'b0;
        pay_left_d          = pay_left_q - LEN_BITS'(1);
        if (pay_left_q == LEN_BITS'(1)) begin
          phase_d = PH_HEADER;
        end
      end

      PH_HALTED: begin
        phase_d = PH_HALTED;
      end

      default: begin
        phase_d = PH_HALTED;
      end
    endcase
  end

  assign res_valid_o = fire && res_valid;
  assign res_o       = res;

  // Parser state advances only on a consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      bytes_left_q <= '0;
      acc_q        <= '0;
      shift_q      <= '0;
      open_q       <= 1'b1;
      pay_left_q   <= '0;
      first_q      <= 1'b0;
    end else if (fire) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      shift_q      <= shift_d;
      open_q       <= open_d;
      pay_left_q   <= pay_left_d;
      first_q      <= first_d;
    end
  end

  // While in the payload phase at least one payload byte remains.
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (pay_left_q != '0))
    else $error("payload phase with no bytes left");

  // While decoding the length at least one counted length byte remains.
  a_length_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LENGTH) |-> (bytes_left_q != 4'd0))
    else $error("length phase with no length bytes left");

  // An error result always leaves the parser halted.
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res.error_code != ERR_NONE)) |=> (phase_q == PH_HALTED))
    else $error("error result without halting");

  // The first-byte mark only appears on a payload byte.
  a_first_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res.first_of_record) |->
      (!res.empty_record && (res.error_code == ERR_NONE) && (phase_cur == PH_PAYLOAD)))
    else $error("first mark outside a payload byte");

endmodule
